### src/nsht_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package nsht_pkg;

  // Field widths fixed by the item format
  localparam int COORD_W    = 32;             // Q16.16 coordinates and directions
  localparam int DP_W       = COORD_W + 1;    // start-point difference
  localparam int PROD_W     = 2 * COORD_W;    // cross-product terms
  localparam int THRESH_W   = 40;             // parallel threshold, Q8.32
  localparam int FRAC_OUT_W = 17;             // reported fraction

  localparam logic [THRESH_W-1:0] THRESH_RESET = 40'd429497;

  typedef logic signed [COORD_W-1:0] coord_t;

endpackage

`default_nettype wire

### src/nsht_pair_if.sv
`timescale 1ns / 1ps
`default_nettype none

// Segment pair item: wall segment and moving segment
interface nsht_pair_if import nsht_pkg::*; ();
  logic   valid;
  logic   ready;
  logic   new_query;
  coord_t wall_start_x;
  coord_t wall_start_y;
  coord_t wall_dir_x;
  coord_t wall_dir_y;
  coord_t ray_start_x;
  coord_t ray_start_y;
  coord_t ray_dir_x;
  coord_t ray_dir_y;

  modport source (
    output valid, new_query, wall_start_x, wall_start_y, wall_dir_x, wall_dir_y,
           ray_start_x, ray_start_y, ray_dir_x, ray_dir_y,
    input  ready
  );

  modport sink (
    input  valid, new_query, wall_start_x, wall_start_y, wall_dir_x, wall_dir_y,
           ray_start_x, ray_start_y, ray_dir_x, ray_dir_y,
    output ready
  );
endinterface

`default_nettype wire

### src/nsht_hit_if.sv
`timescale 1ns / 1ps
`default_nettype none

// Best-hit item
interface nsht_hit_if import nsht_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic                  hit_found;
  logic [FRAC_OUT_W-1:0] hit_fraction;
  coord_t                normal_x;
  coord_t                normal_y;

  modport source (
    output valid, hit_found, hit_fraction, normal_x, normal_y,
    input  ready
  );

  modport sink (
    input  valid, hit_found, hit_fraction, normal_x, normal_y,
    output ready
  );
endinterface

`default_nettype wire

### src/nearest_segment_hit_tracker.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  Handshake        Payload
// pair      in   valid / ready    new_query, wall start/dir x,y, ray start/dir x,y
// hit       out  valid / ready    hit_found, hit_fraction, normal_x, normal_y
// cfg       in   cfg_we only      cfg_wdata (parallel threshold, Q8.32)
//
// One item at a time: bit-serial shift-add in S_MUL builds the four cross-product terms,
// S_DIFF, S_MAG and S_TEST form and test the denominator, the restoring divider in S_DIV
// yields FRACTION_BITS quotient bits, and S_NEAR, S_WALL and S_DONE finish; when v = 1 the
// divide is skipped, and on reject the test goes straight to S_DONE and the output register.
// The next item can be taken as soon as the result sits in the output register.
// rst (synchronous) clears the best hit and loads THRESH_RESET as threshold; a stalled hit item holds S_DONE.

module nearest_segment_hit_tracker import nsht_pkg::*; #(
  parameter int FRACTION_BITS = 16
) (
  input  logic                clk,
  input  logic                rst,
  nsht_pair_if.sink           pair,
  nsht_hit_if.source          hit,
  input  logic                cfg_we,
  input  logic [THRESH_W-1:0] cfg_wdata
);

  localparam int VQ_W  = FRACTION_BITS + 1;
  localparam int NUM_W = COORD_W + FRACTION_BITS + 2;
  localparam int CNT_W = $clog2(COORD_W);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_MUL  = 4'd1;
  localparam logic [3:0] S_DIFF = 4'd2;
  localparam logic [3:0] S_MAG  = 4'd3;
  localparam logic [3:0] S_TEST = 4'd4;
  localparam logic [3:0] S_DIV  = 4'd5;
  localparam logic [3:0] S_NEAR = 4'd6;
  localparam logic [3:0] S_WALL = 4'd7;
  localparam logic [3:0] S_DONE = 4'd8;

  // Horner step, multiplier MSB first; the sign bit carries negative weight
  function automatic logic [PROD_W-1:0] mac_step(input logic [PROD_W-1:0] a,
                                                 input logic [PROD_W-1:0] m,
                                                 input logic b,
                                                 input logic neg);
    logic [PROD_W-1:0] t;
    t = b ? (m ^ {PROD_W{neg}}) : '0;
    return {a[PROD_W-2:0], 1'b0} + t + PROD_W'(b & neg);
  endfunction

  function automatic logic [COORD_W-1:0] abs32(input logic [COORD_W-1:0] x);
    return x[COORD_W-1] ? (~x + 1'b1) : x;
  endfunction

  logic [3:0]          state;
  logic [CNT_W-1:0]    cnt;
  logic [THRESH_W-1:0] thr;

  logic [COORD_W-1:0]  d1x, d1y, d2x, d2y;
  logic [DP_W-1:0]     dpx, dpy;
  logic [COORD_W-1:0]  mx, my;
  logic [PROD_W-1:0]   pa, pb, pc, pd;
  logic [PROD_W:0]     den_raw, nom_raw;
  logic [PROD_W-1:0]   den_mag, rem;
  logic                den_neg, nom_neg, axis_x, near;
  logic [VQ_W-1:0]     vq;
  logic [NUM_W-1:0]    acc, num;

  logic                best_valid;
  logic [VQ_W-1:0]     best_fraction;
  logic [COORD_W-1:0]  best_nx, best_ny;

  logic                  out_valid, out_found;
  logic [FRAC_OUT_W-1:0] out_frac;
  logic [COORD_W-1:0]    out_nx, out_ny;

  // Operand selection and sign extensions
  logic                   first, accept, load_out;
  logic [PROD_W-1:0]      m_d2x, m_d2y, m_dpx, m_dpy;
  logic [COORD_W-1:0]     d1sel, d2sel;
  logic [DP_W-1:0]        dpsel;
  logic [NUM_W-1:0]       d2_ext, dp_scaled, div_scaled;
  logic [PROD_W-1:0]      rem2;
  logic                   take, pass, wall_ok;
  logic [VQ_W+FRAC_OUT_W-1:0] frac_wide;

  assign accept   = pair.valid && pair.ready;
  assign first    = (cnt == CNT_W'(COORD_W - 1));
  assign load_out = (state == S_DONE) && (!out_valid || hit.ready);

  assign m_d2x = {{(PROD_W-COORD_W){d2x[COORD_W-1]}}, d2x};
  assign m_d2y = {{(PROD_W-COORD_W){d2y[COORD_W-1]}}, d2y};
  assign m_dpx = {{(PROD_W-DP_W){dpx[DP_W-1]}}, dpx};
  assign m_dpy = {{(PROD_W-DP_W){dpy[DP_W-1]}}, dpy};

  assign d1sel = axis_x ? d1x : d1y;
  assign d2sel = axis_x ? d2x : d2y;
  assign dpsel = axis_x ? dpx : dpy;

  assign d2_ext     = {{(NUM_W-COORD_W){d2sel[COORD_W-1]}}, d2sel};
  assign dp_scaled  = {{(NUM_W-DP_W){dpsel[DP_W-1]}}, dpsel} << FRACTION_BITS;
  assign div_scaled = {{(NUM_W-COORD_W){d1sel[COORD_W-1]}}, d1sel} << FRACTION_BITS;

  // Restoring divider step
  assign rem2 = {rem[PROD_W-2:0], 1'b0};
  assign take = (rem2 >= den_mag);

  // Denominator not parallel, 0 <= v <= 1
  assign pass = (den_mag > {{(PROD_W-THRESH_W){1'b0}}, thr})
             && ((rem == '0) || (nom_neg == den_neg))
             && (rem <= den_mag);

  // 0 <= u <= 1 on the chosen wall axis
  assign wall_ok = (d1sel != '0) &&
                   (d1sel[COORD_W-1] ?
                     (($signed(num) <= 0) && ($signed(num) >= $signed(div_scaled))) :
                     (($signed(num) >= 0) && ($signed(num) <= $signed(div_scaled))));

  assign frac_wide = {{FRAC_OUT_W{1'b0}}, best_fraction};

  // Sequencer and datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      thr           <= THRESH_RESET;
      best_valid    <= 1'b0;
      best_fraction <= '0;
      best_nx       <= '0;
      best_ny       <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_we) begin
        thr <= cfg_wdata;
      end

      if (load_out) begin
        out_valid <= 1'b1;
      end else if (hit.ready) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (accept) begin
            d1x <= pair.wall_dir_x;
            d1y <= pair.wall_dir_y;
            d2x <= pair.ray_dir_x;
            d2y <= pair.ray_dir_y;
            mx  <= pair.wall_dir_x;
            my  <= pair.wall_dir_y;
            dpx <= {pair.ray_start_x[COORD_W-1], pair.ray_start_x}
                 - {pair.wall_start_x[COORD_W-1], pair.wall_start_x};
            dpy <= {pair.ray_start_y[COORD_W-1], pair.ray_start_y}
                 - {pair.wall_start_y[COORD_W-1], pair.wall_start_y};
            pa  <= '0;
            pb  <= '0;
            pc  <= '0;
            pd  <= '0;
            cnt <= CNT_W'(COORD_W - 1);
            if (pair.new_query) begin
              best_valid    <= 1'b0;
              best_fraction <= '0;
              best_nx       <= '0;
              best_ny       <= '0;
            end
            state <= S_MUL;
          end
        end

        // d2y*d1x, d2x*d1y, dpx*d1y, dpy*d1x, one multiplier bit a cycle
        S_MUL: begin
          pa <= mac_step(pa, m_d2y, mx[COORD_W-1], first);
          pb <= mac_step(pb, m_d2x, my[COORD_W-1], first);
          pc <= mac_step(pc, m_dpx, my[COORD_W-1], first);
          pd <= mac_step(pd, m_dpy, mx[COORD_W-1], first);
          mx <= {mx[COORD_W-2:0], 1'b0};
          my <= {my[COORD_W-2:0], 1'b0};
          if (cnt == '0) begin
            state <= S_DIFF;
          end else begin
            cnt <= cnt - 1'b1;
          end
        end

        S_DIFF: begin
          den_raw <= {pa[PROD_W-1], pa} - {pb[PROD_W-1], pb};
          nom_raw <= {pc[PROD_W-1], pc} - {pd[PROD_W-1], pd};
          axis_x  <= abs32(d1x) > abs32(d1y);
          state   <= S_MAG;
        end

        S_MAG: begin
          den_neg <= den_raw[PROD_W];
          nom_neg <= nom_raw[PROD_W];
          den_mag <= den_raw[PROD_W] ? (~den_raw[PROD_W-1:0] + 1'b1) : den_raw[PROD_W-1:0];
          rem     <= nom_raw[PROD_W] ? (~nom_raw[PROD_W-1:0] + 1'b1) : nom_raw[PROD_W-1:0];
          state   <= S_TEST;
        end

        S_TEST: begin
          if (!pass) begin
            state <= S_DONE;
          end else if (rem == den_mag) begin
            // v is exactly one
            vq    <= VQ_W'(1) << FRACTION_BITS;
            acc   <= d2_ext << FRACTION_BITS;
            state <= S_NEAR;
          end else begin
            vq    <= '0;
            acc   <= '0;
            cnt   <= CNT_W'(FRACTION_BITS - 1);
            state <= S_DIV;
          end
        end

        // One quotient bit a cycle; acc follows d2sel * vq alongside
        S_DIV: begin
          rem <= take ? (rem2 - den_mag) : rem2;
          vq  <= {vq[VQ_W-2:0], take};
          acc <= {acc[NUM_W-2:0], 1'b0} + (take ? d2_ext : '0);
          if (cnt == '0) begin
            state <= S_NEAR;
          end else begin
            cnt <= cnt - 1'b1;
          end
        end

        S_NEAR: begin
          near  <= !best_valid || (vq < best_fraction);
          num   <= dp_scaled + acc;
          state <= S_WALL;
        end

        S_WALL: begin
          if (near && wall_ok) begin
            best_valid    <= 1'b1;
            best_fraction <= vq;
            best_nx       <= ~d1y + 1'b1;
            best_ny       <= d1x;
          end
          state <= S_DONE;
        end

        S_DONE: begin
          if (load_out) begin
            out_found <= best_valid;
            out_frac  <= frac_wide[FRAC_OUT_W-1:0];
            out_nx    <= best_nx;
            out_ny    <= best_ny;
            state     <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign pair.ready       = (state == S_IDLE);
  assign hit.valid        = out_valid;
  assign hit.hit_found    = out_found;
  assign hit.hit_fraction = out_frac;
  assign hit.normal_x     = out_nx;
  assign hit.normal_y     = out_ny;

  // Divider remainder stays below the divisor
  a_div_rem: assert property (@(posedge clk) disable iff (rst)
    state == S_DIV |-> rem < den_mag)
    else $error("divider remainder not below divisor");

  // Stored fraction never above one
  a_best_frac: assert property (@(posedge clk) disable iff (rst)
    best_valid |-> best_fraction <= (VQ_W'(1) << FRACTION_BITS))
    else $error("best fraction above one");

  // No hit reports zero fraction and normal
  a_nohit_zero: assert property (@(posedge clk) disable iff (rst)
    hit.valid && !hit.hit_found |->
      hit.hit_fraction == '0 && hit.normal_x == '0 && hit.normal_y == '0)
    else $error("empty result carries data");

  // Accepted item starts the multiply at its top bit
  a_accept_mul: assert property (@(posedge clk) disable iff (rst)
    pair.valid && pair.ready |=> state == S_MUL && cnt == CNT_W'(COORD_W - 1))
    else $error("accepted item did not start multiply");

endmodule

`default_nettype wire
